@@ hdl/esd_pkg.sv @@
package esd_pkg;

	// Decoder state, one-hot.
	typedef enum logic [3:0] {
		MODE_NORMAL = 4'b0001,
		MODE_ESCAPE = 4'b0010,
		MODE_OCTAL  = 4'b0100,
		MODE_HEX    = 4'b1000
	} mode_t;

	localparam logic [7:0] BACKSLASH = 8'h5C;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_X    = 8'h78;

	// Run of octal digits: the leading 0 counts, so three digits close it.
	localparam logic [1:0] OCT_MAX_DIGITS = 2'd3;

	// hex_value result for a byte that is no hex digit.
	localparam logic [4:0] HEX_NONE = 5'd16;

	// Queue between front and back.
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	// One queued word: the results of one input word (one or two bytes).
	typedef struct packed {
		logic       two;    // byte1 follows byte0
		logic [7:0] byte0;
		logic [7:0] byte1;
		logic       last;   // input word closed the string
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic is_octal(input logic [7:0] b);
		return (b inside {[8'h30:8'h37]});
	endfunction

	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] v;
		v = HEX_NONE;
		if (b inside {[8'h30:8'h39]})
			v = 5'(b - 8'h30);
		else if (b inside {[8'h61:8'h66]})
			v = 5'(b - 8'h61 + 8'd10);
		else if (b inside {[8'h41:8'h46]})
			v = 5'(b - 8'h41 + 8'd10);
		return v;
	endfunction

	function automatic logic [7:0] escape_map(input logic [7:0] b);
		logic [7:0] v;
		case (b)
			8'h6E:   v = 8'h0A; // n
			8'h72:   v = 8'h0D; // r
			8'h74:   v = 8'h09; // t
			8'h62:   v = 8'h08; // b
			8'h66:   v = 8'h0C; // f
			8'h61:   v = 8'h07; // a
			8'h76:   v = 8'h0B; // v
			default: v = b;
		endcase
		return v;
	endfunction

endpackage

@@ hdl/esd_front.sv @@
module esd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [7:0]          in_byte,
	input  logic                in_last,
	input  esd_pkg::fifo_stat_t fifo_stat,
	output logic                push,
	output esd_pkg::entry_t     entry
);

	esd_pkg::mode_t mode_q, nxt_mode;
	logic [7:0] acc_q, nxt_acc;
	logic [1:0] cnt_q, nxt_cnt;
	logic [1:0] num;
	logic [7:0] b0, b1;
	logic [7:0] acc_oct;
	logic [1:0] cnt_inc;
	logic [4:0] hex_d;
	logic       accept;
	logic       esc_start;

	assign in_stall = fifo_stat.full;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		nxt_mode  = mode_q;
		nxt_acc   = acc_q;
		nxt_cnt   = cnt_q;
		num       = 2'd0;
		b0        = in_byte;
		b1        = in_byte;
		acc_oct   = {acc_q[4:0], in_byte[2:0]};
		cnt_inc   = cnt_q + 2'd1;
		hex_d     = esd_pkg::hex_value(in_byte);
		esc_start = (in_byte == esd_pkg::BACKSLASH) && !in_last;
		case (mode_q)
			esd_pkg::MODE_NORMAL: begin
				if (esc_start) begin
					nxt_mode = esd_pkg::MODE_ESCAPE;
				end else begin
					num = 2'd1;
				end
			end
			esd_pkg::MODE_ESCAPE: begin
				nxt_mode = esd_pkg::MODE_NORMAL;
				if (in_byte == esd_pkg::CHAR_ZERO) begin
					nxt_mode = esd_pkg::MODE_OCTAL;
					nxt_acc  = 8'd0;
					nxt_cnt  = 2'd1;
				end else if (in_byte == esd_pkg::CHAR_X) begin
					nxt_mode = esd_pkg::MODE_HEX;
					nxt_acc  = 8'd0;
				end else begin
					num = 2'd1;
					b0  = esd_pkg::escape_map(in_byte);
				end
			end
			esd_pkg::MODE_OCTAL: begin
				if (esd_pkg::is_octal(in_byte)) begin
					nxt_acc = acc_oct;
					nxt_cnt = cnt_inc;
					if (cnt_inc == esd_pkg::OCT_MAX_DIGITS || cnt_inc == 2'd0) begin
						num      = 2'd1;
						b0       = acc_oct;
						nxt_mode = esd_pkg::MODE_NORMAL;
						nxt_acc  = 8'd0;
						nxt_cnt  = 2'd0;
					end
				end else begin
					// run ends: pending value, then the byte as fresh text
					b0       = acc_q;
					nxt_mode = esd_pkg::MODE_NORMAL;
					nxt_acc  = 8'd0;
					nxt_cnt  = 2'd0;
					if (esc_start) begin
						num      = 2'd1;
						nxt_mode = esd_pkg::MODE_ESCAPE;
					end else begin
						num = 2'd2;
					end
				end
			end
			esd_pkg::MODE_HEX: begin
				if (hex_d != esd_pkg::HEX_NONE) begin
					nxt_acc = {acc_q[3:0], hex_d[3:0]};
				end else begin
					b0       = acc_q;
					nxt_mode = esd_pkg::MODE_NORMAL;
					nxt_acc  = 8'd0;
					if (esc_start) begin
						num      = 2'd1;
						nxt_mode = esd_pkg::MODE_ESCAPE;
					end else begin
						num = 2'd2;
					end
				end
			end
			default: begin
				nxt_mode = esd_pkg::MODE_NORMAL;
				nxt_acc  = 8'd0;
				nxt_cnt  = 2'd0;
			end
		endcase
		// end of string flushes an open run and clears the state
		if (in_last) begin
			if ((nxt_mode == esd_pkg::MODE_OCTAL || nxt_mode == esd_pkg::MODE_HEX)
					&& num != 2'd2) begin
				if (num == 2'd0) begin
					b0 = nxt_acc;
				end else begin
					b1 = nxt_acc;
				end
				num = num + 2'd1;
			end
			nxt_mode = esd_pkg::MODE_NORMAL;
			nxt_acc  = 8'd0;
			nxt_cnt  = 2'd0;
		end
	end

	assign push        = accept && (num != 2'd0);
	assign entry.two   = (num == 2'd2);
	assign entry.byte0 = b0;
	assign entry.byte1 = b1;
	assign entry.last  = in_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= esd_pkg::MODE_NORMAL;
			acc_q  <= 8'd0;
			cnt_q  <= 2'd0;
		end else if (accept) begin
			mode_q <= nxt_mode;
			acc_q  <= nxt_acc;
			cnt_q  <= nxt_cnt;
		end
	end

	// an open octal run always holds one or two digits
	a_oct_count: assert property (@(posedge clk) disable iff (!arst_n)
		mode_q == esd_pkg::MODE_OCTAL |-> (cnt_q == 2'd1 || cnt_q == 2'd2))
		else $error("octal digit count out of range");

	// the string's last word always yields a result and leaves clean state
	a_last_push: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_last |-> push ##1 (mode_q == esd_pkg::MODE_NORMAL && acc_q == 8'd0))
		else $error("end of string not flushed");

endmodule

@@ hdl/esd_fifo.sv @@
module esd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  esd_pkg::entry_t     wr_entry,
	input  logic                pop,
	output esd_pkg::entry_t     rd_entry,
	output esd_pkg::fifo_stat_t stat
);

	esd_pkg::entry_t mem_q [esd_pkg::FIFO_DEPTH];
	logic [esd_pkg::FIFO_AW-1:0] wr_q, rd_q;
	logic [esd_pkg::FIFO_CW-1:0] cnt_q;

	assign stat.full  = (cnt_q == esd_pkg::FIFO_CW'(esd_pkg::FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rd_entry   = mem_q[rd_q];

	function automatic logic [esd_pkg::FIFO_AW-1:0] ptr_inc(
			input logic [esd_pkg::FIFO_AW-1:0] p);
		return (p == esd_pkg::FIFO_AW'(esd_pkg::FIFO_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= wr_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ptr_inc(wr_q);
			end
			if (pop) begin
				rd_q <= ptr_inc(rd_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && stat.full) && !(pop && stat.empty))
		else $error("queue overflow or underflow");

endmodule

@@ hdl/esd_back.sv @@
module esd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  esd_pkg::entry_t     head,
	input  esd_pkg::fifo_stat_t fifo_stat,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [7:0]          out_byte,
	output logic                run_last,
	output logic                string_end
);

	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       run_last_q;
	logic       string_end_q;
	logic       idx_q;      // first byte of a two-byte word already sent
	logic       load;
	logic       take;
	logic       fin;

	assign load = !out_valid_q || !out_stall;
	assign take = load && !fifo_stat.empty;
	assign fin  = !head.two || idx_q;
	assign pop  = take && fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= 1'b0;
		end else if (take) begin
			out_valid_q <= 1'b1;
			idx_q       <= !fin;
		end else if (load) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_byte_q   <= idx_q ? head.byte1 : head.byte0;
			run_last_q   <= fin;
			string_end_q <= fin && head.last;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_byte   = out_byte_q;
	assign run_last   = run_last_q;
	assign string_end = string_end_q;

	// second byte pending means its word is still at the queue head
	a_idx_head: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q |-> (!fifo_stat.empty && head.two))
		else $error("second byte lost from queue head");

	a_end_is_run_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && string_end_q |-> run_last_q)
		else $error("string end without run end");

endmodule

@@ hdl/escape_sequence_decoder.sv @@
// Streaming unescaper for C string literals. One raw byte enters per word on
// the input channel (in_last marks the string's final byte); each input word
// yields zero, one or two decoded bytes on the output channel. run_last marks
// the final output of an input word, string_end the final output of the
// string. Escapes: \n \r \t \b \f \a \v map to control codes, any other byte
// after a backslash passes through (so \\ \' \" give themselves); \0 opens an
// octal run of up to three digits counting the 0; \x opens a hex run of any
// length keeping the low 8 bits. A byte that ends a run emits the run value
// first, then is decoded as fresh text. A lone trailing backslash is emitted
// as is, and in_last flushes an open run. Rate: one input word per cycle
// while the queue is not full; the output register sends one byte per cycle
// while out_stall is low, so a two-byte word holds the output for both bytes
// while a four-word queue keeps the input flowing. in_stall rises only when
// the queue is full, i.e. when the output side has been stalled.
module escape_sequence_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] out_byte,
	output logic       run_last,
	output logic       string_end
);

	// front -> queue
	logic                push;
	esd_pkg::entry_t     wr_entry;

	// queue -> back
	esd_pkg::entry_t     head;
	esd_pkg::fifo_stat_t fifo_stat;
	logic                pop;

	// Front: decode state machine, classifies each byte into queued results.
	esd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.fifo_stat (fifo_stat),
		.push      (push),
		.entry     (wr_entry)
	);

	// Queue: decouples the decoder from output back-pressure.
	esd_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.rd_entry (head),
		.stat     (fifo_stat)
	);

	// Back: serializes each queued word's bytes into the output register.
	esd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.fifo_stat  (fifo_stat),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.run_last   (run_last),
		.string_end (string_end)
	);

endmodule

@@ dv/escape_sequence_decoder_tb.sv @@
`timescale 1ns / 100ps

module escape_sequence_decoder_tb;

	localparam int STUCK_LIMIT  = 2000; // cycles with no word moving on either side
	localparam int PHASE_WORDS  = 640;  // random words per idling phase
	localparam int DRAIN_CYCLES = 4;    // wait before the final check
	localparam logic [4:0] NOT_HEX = 5'h10;

	// One row of the directed table. Where given is set, count/first/second are
	// the decoded bytes typed in by hand; otherwise the predictor supplies them.
	typedef struct packed {
		logic [7:0] raw;
		logic       last;
		logic       given;
		logic [1:0] count;
		logic [7:0] first;
		logic [7:0] second;
	} stim_row_t;

	// One decoded byte as it leaves the block.
	typedef struct packed {
		logic [7:0] value;
		logic       run_end;
		logic       str_end;
	} decoded_t;

	// Directed part: extremes, each kind of escape, runs ended every way.
	localparam stim_row_t DIRECTED [0:25] = '{
		'{8'h00,              1'b0, 1'b1, 2'd1, 8'h00,              8'h00}, // NUL passes
		'{8'hFF,              1'b0, 1'b1, 2'd1, 8'hFF,              8'h00}, // top byte
		'{esd_pkg::BACKSLASH, 1'b0, 1'b1, 2'd0, 8'h00,              8'h00}, // opens escape
		'{"n",                1'b0, 1'b1, 2'd1, 8'h0A,              8'h00}, // newline
		'{esd_pkg::BACKSLASH, 1'b0, 1'b1, 2'd0, 8'h00,              8'h00},
		'{"q",                1'b0, 1'b1, 2'd1, "q",                8'h00}, // unknown letter
		'{esd_pkg::BACKSLASH, 1'b0, 1'b1, 2'd0, 8'h00,              8'h00},
		'{"0",                1'b0, 1'b1, 2'd0, 8'h00,              8'h00}, // octal run opens
		'{"1",                1'b0, 1'b1, 2'd0, 8'h00,              8'h00},
		'{"7",                1'b0, 1'b0, 2'd0, 8'h00,              8'h00}, // third digit
		'{esd_pkg::BACKSLASH, 1'b0, 1'b1, 2'd0, 8'h00,              8'h00},
		'{"x",                1'b0, 1'b1, 2'd0, 8'h00,              8'h00}, // hex run opens
		'{"F",                1'b0, 1'b1, 2'd0, 8'h00,              8'h00},
		'{"f",                1'b0, 1'b1, 2'd0, 8'h00,              8'h00},
		'{"a",                1'b0, 1'b0, 2'd0, 8'h00,              8'h00}, // value wraps
		'{"G",                1'b0, 1'b0, 2'd0, 8'h00,              8'h00}, // ends hex run
		'{esd_pkg::BACKSLASH, 1'b0, 1'b1, 2'd0, 8'h00,              8'h00},
		'{"0",                1'b0, 1'b1, 2'd0, 8'h00,              8'h00},
		'{"8",                1'b0, 1'b0, 2'd0, 8'h00,              8'h00}, // 8 not octal
		'{esd_pkg::BACKSLASH, 1'b0, 1'b1, 2'd0, 8'h00,              8'h00},
		'{"x",                1'b1, 1'b1, 2'd1, 8'h00,              8'h00}, // empty hex run
		'{esd_pkg::BACKSLASH, 1'b1, 1'b1, 2'd1, esd_pkg::BACKSLASH, 8'h00}, // lone backslash
		'{esd_pkg::BACKSLASH, 1'b0, 1'b1, 2'd0, 8'h00,              8'h00},
		'{"0",                1'b0, 1'b1, 2'd0, 8'h00,              8'h00},
		'{"5",                1'b0, 1'b1, 2'd0, 8'h00,              8'h00},
		'{esd_pkg::BACKSLASH, 1'b1, 1'b0, 2'd0, 8'h00,              8'h00}  // value, backslash
	};

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [7:0] in_byte = 8'h00;
	logic       in_last = 1'b0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [7:0] out_byte;
	logic       run_last;
	logic       string_end;

	// Typed-in expectation travelling alongside the word on the input side.
	logic       word_given = 1'b0;
	logic [1:0] word_count = 2'd0;
	logic [7:0] word_first = 8'h00;
	logic [7:0] word_second = 8'h00;

	int unsigned src_idle_pct = 0;
	int unsigned dst_stall_pct = 0;
	int unsigned words_sent = 0;
	int unsigned errors = 0;
	int unsigned stuck_cycles = 0;

	decoded_t pending_decoded[$];

	// Predictor state.
	esd_pkg::mode_t lit_mode = esd_pkg::MODE_NORMAL;
	logic [7:0]     run_value = 8'h00;
	logic [1:0]     octal_taken = 2'd0;

	escape_sequence_decoder DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_byte  (out_byte),
		.run_last  (run_last),
		.string_end(string_end)
	);

	always #10 clk = ~clk;

	// Receiver: random stall at the current rate.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < dst_stall_pct);
	end

	function automatic logic [4:0] nibble_of(input logic [7:0] c);
		if (c >= "0" && c <= "9")
			return {1'b0, c[3:0]};
		if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F"))
			return {1'b0, c[3:0] + 4'd9};
		return NOT_HEX;
	endfunction

	function automatic logic [7:0] control_code(input logic [7:0] c);
		case (c)
			"n":     return 8'h0A;
			"r":     return 8'h0D;
			"t":     return 8'h09;
			"b":     return 8'h08;
			"f":     return 8'h0C;
			"a":     return 8'h07;
			"v":     return 8'h0B;
			default: return c;
		endcase
	endfunction

	// Decodes one accepted word: returns 0..2 bytes and advances the state.
	task automatic unescape_word(input logic [7:0] c, input logic last, output int n,
			output logic [7:0] b0, output logic [7:0] b1);
		logic       plain;
		logic [4:0] nib;
		n = 0;
		b0 = 8'h00;
		b1 = 8'h00;
		plain = 1'b0;
		case (lit_mode)
			esd_pkg::MODE_NORMAL: plain = 1'b1;
			esd_pkg::MODE_ESCAPE: begin
				lit_mode = esd_pkg::MODE_NORMAL;
				if (c == esd_pkg::CHAR_ZERO) begin
					lit_mode = esd_pkg::MODE_OCTAL;
					run_value = 8'h00;
					octal_taken = 2'd1;
				end else if (c == esd_pkg::CHAR_X) begin
					lit_mode = esd_pkg::MODE_HEX;
					run_value = 8'h00;
				end else begin
					b0 = control_code(c);
					n = 1;
				end
			end
			esd_pkg::MODE_OCTAL: begin
				if (c >= "0" && c <= "7") begin
					run_value = {run_value[4:0], c[2:0]};
					octal_taken = octal_taken + 2'd1;
					if (octal_taken == esd_pkg::OCT_MAX_DIGITS) begin
						b0 = run_value;
						n = 1;
						lit_mode = esd_pkg::MODE_NORMAL;
						run_value = 8'h00;
						octal_taken = 2'd0;
					end
				end else begin
					// run closed by a non-digit: value out, byte decoded afresh
					b0 = run_value;
					n = 1;
					lit_mode = esd_pkg::MODE_NORMAL;
					run_value = 8'h00;
					octal_taken = 2'd0;
					plain = 1'b1;
				end
			end
			default: begin
				nib = nibble_of(c);
				if (nib != NOT_HEX) begin
					run_value = {run_value[3:0], nib[3:0]};
				end else begin
					b0 = run_value;
					n = 1;
					lit_mode = esd_pkg::MODE_NORMAL;
					run_value = 8'h00;
					plain = 1'b1;
				end
			end
		endcase
		if (plain) begin
			if (c == esd_pkg::BACKSLASH && !last) begin
				lit_mode = esd_pkg::MODE_ESCAPE;
			end else begin
				if (n == 0) b0 = c;
				else b1 = c;
				n++;
			end
		end
		// end of string flushes an open run and clears everything
		if (last) begin
			if ((lit_mode == esd_pkg::MODE_OCTAL || lit_mode == esd_pkg::MODE_HEX)
					&& n < 2) begin
				if (n == 0) b0 = run_value;
				else b1 = run_value;
				n++;
			end
			lit_mode = esd_pkg::MODE_NORMAL;
			run_value = 8'h00;
			octal_taken = 2'd0;
		end
	endtask

	function automatic void report_error(input string what, input decoded_t want,
			input decoded_t got);
		errors++;
		if (errors <= 10)
			$display("%0t: %s: expected byte %02h run_last %b string_end %b, got %02h %b %b",
				$realtime, what, want.value, want.run_end, want.str_end,
				got.value, got.run_end, got.str_end);
	endfunction

	// Scoreboard: samples both channels at the edge, predicts on every accepted
	// input word and checks every accepted output word against the oldest entry.
	always @(posedge clk) begin : scoreboard
		int         n;
		logic [7:0] b0;
		logic [7:0] b1;
		logic       took;
		decoded_t   got;
		decoded_t   want;
		took = 1'b0;
		if (arst_n && in_valid && !in_stall) begin
			took = 1'b1;
			unescape_word(in_byte, in_last, n, b0, b1);
			if (word_given) begin
				n = int'(word_count);
				b0 = word_first;
				b1 = word_second;
			end
			for (int k = 0; k < n; k++) begin
				want.value = (k == 0) ? b0 : b1;
				want.run_end = (k == n - 1);
				want.str_end = (k == n - 1) && in_last;
				pending_decoded.push_back(want);
			end
		end
		if (arst_n && out_valid && !out_stall) begin
			took = 1'b1;
			got = '{out_byte, run_last, string_end};
			if (pending_decoded.size() == 0) begin
				report_error("unexpected word", got, got);
			end else begin
				want = pending_decoded.pop_front();
				if (got.value !== want.value || got.run_end !== want.run_end ||
						got.str_end !== want.str_end)
					report_error("mismatch", want, got);
			end
		end
		if (!arst_n || took)
			stuck_cycles <= 0;
		else
			stuck_cycles <= stuck_cycles + 1;
	end

	// Sender: random idle cycles, then hold the word until it is taken.
	task automatic send_word(input logic [7:0] c, input logic last, input logic given,
			input logic [1:0] count, input logic [7:0] b0, input logic [7:0] b1);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_byte <= c;
		in_last <= last;
		word_given <= given;
		word_count <= count;
		word_first <= b0;
		word_second <= b1;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	// Sender holds off until every decoded byte has come out.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_decoded.size() != 0) @(posedge clk);
	endtask

	// Mostly well-formed literals built from pieces; a tenth is raw noise.
	task automatic send_random_string();
		logic [7:0] lit[$];
		int         pieces;
		int         digits;
		int unsigned pick;
		int unsigned nib;
		string      letters;
		letters = "nrtbfav\\'\"";
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(6, 1)) lit.push_back(8'($urandom_range(255)));
		end else begin
			pieces = $urandom_range(8, 1);
			repeat (pieces) begin
				pick = $urandom_range(99);
				if (pick < 35) begin
					lit.push_back(8'($urandom_range(255)));
				end else if (pick < 55) begin
					lit.push_back(esd_pkg::BACKSLASH);
					if ($urandom_range(3) == 0)
						lit.push_back(8'($urandom_range(255)));
					else
						lit.push_back(letters[$urandom_range(letters.len() - 1)]);
				end else if (pick < 75) begin
					// \0 plus up to three more digits; a fourth is plain text
					lit.push_back(esd_pkg::BACKSLASH);
					lit.push_back(esd_pkg::CHAR_ZERO);
					digits = $urandom_range(3);
					repeat (digits) lit.push_back(8'("0" + $urandom_range(7)));
					if ($urandom_range(4) == 0)
						lit.push_back(8'("8" + $urandom_range(1)));
				end else if (pick < 95) begin
					lit.push_back(esd_pkg::BACKSLASH);
					lit.push_back(esd_pkg::CHAR_X);
					digits = $urandom_range(4);
					repeat (digits) begin
						nib = $urandom_range(15);
						if (nib < 10)
							lit.push_back(8'("0" + nib));
						else if ($urandom_range(1) == 0)
							lit.push_back(8'("a" + nib - 10));
						else
							lit.push_back(8'("A" + nib - 10));
					end
				end else begin
					// stray backslash or any byte
					if ($urandom_range(1) == 0)
						lit.push_back(esd_pkg::BACKSLASH);
					else
						lit.push_back(8'($urandom_range(255)));
				end
			end
		end
		foreach (lit[i])
			send_word(lit[i], i == lit.size() - 1, 1'b0, 2'd0, 8'h00, 8'h00);
	endtask

	// Watchdog: nothing moved for too long.
	initial begin
		wait (stuck_cycles >= STUCK_LIMIT);
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		int unsigned target;
		src_idle_pct = 37;
		dst_stall_pct = 65;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i])
			send_word(DIRECTED[i].raw, DIRECTED[i].last, DIRECTED[i].given,
				DIRECTED[i].count, DIRECTED[i].first, DIRECTED[i].second);
		wait_drained();

		// Three idling phases: receiver-heavy gaps, sender-heavy gaps, none.
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					src_idle_pct = 37;
					dst_stall_pct = 65;
				end
				1: begin
					src_idle_pct = 65;
					dst_stall_pct = 37;
				end
				default: begin
					src_idle_pct = 0;
					dst_stall_pct = 0;
				end
			endcase
			target = words_sent + PHASE_WORDS;
			while (words_sent < target) send_random_string();
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending_decoded.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

@@ filelist.f @@
hdl/esd_pkg.sv
hdl/esd_front.sv
hdl/esd_fifo.sv
hdl/esd_back.sv
hdl/escape_sequence_decoder.sv
dv/escape_sequence_decoder_tb.sv
